/* rtl/rtbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbp_pkg: shared types and constants of the RGB threshold bitmap packer
// Field widths, configuration register indexes and the pixel word passed
// from the input stage to the packing stage.
// ----------------------------------------------------------------------------
package rtbp_pkg;

	// Channel and output byte widths.
	localparam int CHAN_W      = 8;
	localparam int BYTE_W      = 8;
	localparam int PIX_DATA_W  = 3 * CHAN_W;

	// Configuration register widths and indexes.
	localparam int ROW_WIDTH_W = 13;
	localparam int THRESH_W    = 8;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESHOLD = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd960;
	localparam logic [THRESH_W-1:0]    THRESH_RST    = 8'd127;

	// One thresholded pixel handed to the packer.
	typedef struct packed {
		logic valid;
		logic white;
	} pix_bit_t;

endpackage

/* rtl/rtbp_input.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbp_input: pixel input register and gray threshold
// Registers one RGB word and decides whether its gray level lies above the
// threshold. The register refills in the same cycle that the packer takes it.
// ----------------------------------------------------------------------------
module rtbp_input (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: red[7:0], green[15:8], blue[23:16].
	input  logic [rtbp_pkg::PIX_DATA_W-1:0]      s_tdata,
	input  logic [rtbp_pkg::THRESH_W-1:0]        gray_threshold,
	output rtbp_pkg::pix_bit_t                   pix,
	input  logic                                 take
);
	import rtbp_pkg::*;

	logic                valid_s1;
	logic [CHAN_W-1:0]   red_s1;
	logic [CHAN_W-1:0]   green_s1;
	logic [CHAN_W-1:0]   blue_s1;
	logic [CHAN_W+1:0]   sum;
	logic [CHAN_W+2:0]   limit;

	assign s_tready = !valid_s1 || take;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Pixel payload, loaded on each accepted word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			red_s1   <= s_tdata[CHAN_W-1:0];
			green_s1 <= s_tdata[2*CHAN_W-1:CHAN_W];
			blue_s1  <= s_tdata[3*CHAN_W-1:2*CHAN_W];
		end
	end

	// floor(sum / 3) > T holds exactly when sum >= 3 * T + 3, so no divider
	// is needed.
	assign sum   = {2'b00, red_s1} + {2'b00, green_s1} + {2'b00, blue_s1};
	assign limit = ({3'b000, gray_threshold} << 1) + {3'b000, gray_threshold}
		+ (CHAN_W+3)'(3);

	assign pix.valid = valid_s1;
	assign pix.white = ({1'b0, sum} >= limit);

endmodule

/* rtl/rtbp_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbp_packer: bit packing, row flush and padding
// Packs one bit per pixel MSB first, flushes the partial byte at the end of
// a row and adds zero bytes up to a 4-byte row boundary. The bytes of one
// pixel sit in a burst register that drains one word per unstalled cycle.
// ----------------------------------------------------------------------------
module rtbp_packer #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rtbp_pkg::pix_bit_t                  pix,
	output logic                                take,
	input  logic [rtbp_pkg::ROW_WIDTH_W-1:0]    row_width,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rtbp_pkg::BYTE_W-1:0]         m_tdata,
	output logic                                m_tlast
);
	import rtbp_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROW_WIDTH);
	localparam int CMP_W = ((ROW_WIDTH_W > CNT_W) ? ROW_WIDTH_W : CNT_W) + 2;

	// Packing state.
	logic [BYTE_W-1:0] acc_q;
	logic [2:0]        pos_q;
	logic [CNT_W-1:0]  col_q;
	logic [1:0]        phase_q;

	// Burst register: byte on the port, words left, row end flag.
	logic [BYTE_W-1:0] byte_q;
	logic [2:0]        rem_q;
	logic              row_end_q;

	logic [BYTE_W-1:0] acc_set;
	logic              full;
	logic              row_done;
	logic              has_data;
	logic [1:0]        phase_one;
	logic [1:0]        pads;
	logic [2:0]        n_bytes;
	logic [CMP_W-1:0]  rw_ext;
	logic [CMP_W-1:0]  max_ext;
	logic [CMP_W-1:0]  eff_width;
	logic              out_fire;

	assign out_fire = m_tvalid && m_tready;
	assign take     = pix.valid && ((rem_q == 3'd0) || (rem_q == 3'd1 && m_tready));

	// Effective row width: zero counts as one, large values saturate.
	assign rw_ext    = CMP_W'(row_width);
	assign max_ext   = CMP_W'(MAX_ROW_WIDTH);
	assign eff_width = (rw_ext == '0) ? CMP_W'(1) : ((rw_ext > max_ext) ? max_ext : rw_ext);

	// Per-pixel byte decisions.
	always_comb begin
		acc_set   = acc_q | (BYTE_W'(pix.white) << pos_q);
		full      = (pos_q == 3'd0);
		row_done  = ((CMP_W'(col_q) + CMP_W'(1)) >= eff_width);
		has_data  = full || row_done;
		phase_one = has_data ? (phase_q + 2'd1) : phase_q;
		pads      = row_done ? (2'd0 - phase_one) : 2'd0;
		n_bytes   = {2'b00, has_data} + {1'b0, pads};
	end

	// Packing state update, one pixel per taken word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pos_q   <= 3'd7;
			col_q   <= '0;
			phase_q <= 2'd0;
		end else if (take) begin
			if (has_data) begin
				acc_q <= '0;
				pos_q <= 3'd7;
			end else begin
				acc_q <= acc_set;
				pos_q <= pos_q - 3'd1;
			end
			if (row_done) begin
				col_q   <= '0;
				phase_q <= 2'd0;
			end else begin
				col_q   <= col_q + CNT_W'(1);
				phase_q <= phase_one;
			end
		end
	end

	// Burst register: load on take, otherwise count down as words leave.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= 3'd0;
			row_end_q <= 1'b0;
		end else if (take) begin
			rem_q     <= n_bytes;
			row_end_q <= row_done;
		end else if (out_fire) begin
			rem_q     <= rem_q - 3'd1;
		end
	end

	// Output byte: the data byte first, zero padding after it.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= has_data ? acc_set : '0;
		end else if (out_fire) begin
			byte_q <= '0;
		end
	end

	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata  = byte_q;
	assign m_tlast  = row_end_q && (rem_q == 3'd1);

endmodule

/* rtl/rgb_threshold_1bpp_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_threshold_1bpp_packer: RGB to 1 bit per pixel bitmap rows
// Thresholds RGB pixels on their gray level and packs them into BMP-style
// 1bpp rows padded to a multiple of 4 bytes.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock unless the input stalls. A pixel that
// completes no byte leaves nothing, one that completes a byte leaves one
// word, and the last pixel of a row can leave up to four words (flushed
// byte plus zero padding); the output drains one word per cycle from a
// burst register while m_tready is high, so the input can stall at each row
// end. A pixel's byte passes the input register and then the burst register
// before it is offered on the output. The row width is clamped to
// 1..MAX_ROW_WIDTH; changing it mid-row ends the current row as soon as its
// column count reaches the new width. Configuration is to be written by
// the user while the block is idle; the block itself does not enforce this.
module rgb_threshold_1bpp_packer #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [rtbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtbp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Pixel input.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: red[7:0], green[15:8], blue[23:16].
	input  logic [rtbp_pkg::PIX_DATA_W-1:0]     s_tdata,
	// Byte output.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0: packed_byte[7:0].
	output logic [rtbp_pkg::BYTE_W-1:0]         m_tdata,
	output logic                                m_tlast
);
	import rtbp_pkg::*;

	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [THRESH_W-1:0]    gray_threshold_q;
	pix_bit_t               pix;
	logic                   take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q      <= ROW_WIDTH_RST;
			gray_threshold_q <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_WIDTH: begin
					row_width_q <= cfg_data[ROW_WIDTH_W-1:0];
				end
				REG_GRAY_THRESHOLD: begin
					gray_threshold_q <= cfg_data[THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rtbp_input u_input (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.gray_threshold (gray_threshold_q),
		.pix            (pix),
		.take           (take)
	);

	rtbp_packer #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.take      (take),
		.row_width (row_width_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

/* rtl/rtbp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbp_port_checks: port-level checks of the bitmap packer
// Watches the stream ports for stalls, output latency and row padding.
// ----------------------------------------------------------------------------
module rtbp_port_checks (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [rtbp_pkg::BYTE_W-1:0]         m_tdata,
	input logic                                m_tlast
);
	import rtbp_pkg::*;

	logic [1:0] byte_phase_q;

	// Words delivered in the current row, modulo 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_phase_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			byte_phase_q <= byte_phase_q + 2'd1;
		end
	end

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// The input only stalls while output words are waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output pending");

	// Output only starts after a pixel was taken.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without a pixel behind it");

	// Every row ends on a 4-byte boundary.
	a_row_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |-> byte_phase_q == 2'd3)
		else $error("row not padded to a multiple of four bytes");

endmodule

bind rgb_threshold_1bpp_packer rtbp_port_checks u_rtbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* bench/rtbp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbp_checker: scoreboard of the RGB threshold bitmap packer
// Watches the configuration port and both stream channels. It keeps its own
// copy of the registers and the packing state, predicts the bytes that each
// taken pixel causes, and compares every output word with the oldest one.
// ----------------------------------------------------------------------------
module rtbp_checker #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rtbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtbp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// Fields from bit 0: red[7:0], green[15:8], blue[23:16].
	input  logic [rtbp_pkg::PIX_DATA_W-1:0]   s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// Fields from bit 0: packed_byte[7:0].
	input  logic [rtbp_pkg::BYTE_W-1:0]       m_tdata,
	input  logic                              m_tlast,
	output int                                errors,
	output int                                outstanding
);
	import rtbp_pkg::*;

	// One output word as it should appear on the byte channel.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} bmp_word_t;

	bmp_word_t              bytes_due[$];
	int                     fail_cnt;

	// Private copy of the registers and of the packing state.
	logic [ROW_WIDTH_W-1:0] row_width_cfg;
	logic [THRESH_W-1:0]    thresh_cfg;
	logic [BYTE_W-1:0]      bit_acc;
	logic [2:0]             bit_pos;
	logic [12:0]            col_cnt;
	logic [1:0]             row_phase;

	// Work out the bytes that one pixel releases and queue them in order.
	task automatic pack_pixel(input logic [PIX_DATA_W-1:0] word);
		logic [9:0]        sum;
		logic [7:0]        gray;
		logic [BYTE_W-1:0] burst[4];
		int                width;
		int                n;
		bit                row_done;
		sum  = {2'b00, word[7:0]} + {2'b00, word[15:8]} + {2'b00, word[23:16]};
		gray = 8'(sum / 10'd3);
		width = int'(row_width_cfg);
		if (width == 0) begin
			width = 1;
		end
		if (width > MAX_ROW_WIDTH) begin
			width = MAX_ROW_WIDTH;
		end
		n = 0;

		if (gray > thresh_cfg) begin
			bit_acc[bit_pos] = 1'b1;
		end
		if (bit_pos == 3'd0) begin
			burst[n]  = bit_acc;
			n++;
			row_phase = row_phase + 2'd1;
			bit_acc   = '0;
			bit_pos   = 3'd7;
		end else begin
			bit_pos = bit_pos - 3'd1;
		end

		// A finished row flushes its partial byte and pads to four bytes.
		row_done = (int'(col_cnt) + 1 >= width);
		if (row_done) begin
			col_cnt = '0;
			if (bit_pos != 3'd7) begin
				burst[n]  = bit_acc;
				n++;
				row_phase = row_phase + 2'd1;
				bit_acc   = '0;
				bit_pos   = 3'd7;
			end
			while (row_phase != 2'd0 && n < 4) begin
				burst[n]  = '0;
				n++;
				row_phase = row_phase + 2'd1;
			end
		end else begin
			col_cnt = col_cnt + 13'd1;
		end

		for (int i = 0; i < n; i++) begin
			bytes_due.push_back('{data: burst[i], last: row_done && (i == n - 1)});
		end
	endtask

	// Count a failure and describe the first ten of them.
	task automatic flag_word(input string what, input bmp_word_t want);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("rtbp_checker: %s: expected byte %02h last %0b, got byte %02h last %0b",
				what, want.data, want.last, m_tdata, m_tlast);
		end
	endtask

	// Compare first, then predict: a word leaving now never stems from a
	// pixel taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		bmp_word_t want;
		if (!arst_n) begin
			bytes_due.delete();
			fail_cnt      = 0;
			row_width_cfg = ROW_WIDTH_RST;
			thresh_cfg    = THRESH_RST;
			bit_acc       = '0;
			bit_pos       = 3'd7;
			col_cnt       = '0;
			row_phase     = '0;
			errors       <= 0;
			outstanding  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (bytes_due.size() == 0) begin
					flag_word("word with none due", '0);
				end else begin
					want = bytes_due.pop_front();
					if (m_tdata !== want.data || m_tlast !== want.last) begin
						flag_word("word mismatch", want);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_WIDTH: begin
						row_width_cfg = cfg_data[ROW_WIDTH_W-1:0];
					end
					REG_GRAY_THRESHOLD: begin
						thresh_cfg = cfg_data[THRESH_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				pack_pixel(s_tdata);
			end
			errors      <= fail_cnt;
			outstanding <= bytes_due.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the RGB threshold bitmap packer
// Drives pixels and register writes, stalls both channels at random and
// leaves all checking to the scoreboard that sits beside the block.
// ----------------------------------------------------------------------------
module tb;
	import rtbp_pkg::*;

	localparam int MAX_W         = 4096;
	localparam int RANDOM_PIXELS = 410;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 300000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ROW_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// Fields from bit 0: red[7:0], green[15:8], blue[23:16].
	logic [PIX_DATA_W-1:0] s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// Fields from bit 0: packed_byte[7:0].
	logic [BYTE_W-1:0]     m_tdata;
	logic                  m_tlast;

	int                    errors;
	int                    outstanding;
	bit                    tx_fast    = 1'b0;
	bit                    rx_fast    = 1'b0;
	int unsigned           stall_left = 0;
	int unsigned           stall_next;
	int unsigned           cycle_count = 0;

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rgb_threshold_1bpp_packer #(
		.MAX_ROW_WIDTH(MAX_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	rtbp_checker #(
		.MAX_ROW_WIDTH(MAX_W)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.errors     (errors),
		.outstanding(outstanding)
	);

	// Byte receiver: after each word it holds tready low for a random stall.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			stall_next = rx_fast ? 0 : $urandom_range(0, 19);
			stall_left <= stall_next;
			m_tready   <= (stall_next == 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			m_tready   <= 1'b1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// One register write; the extra edge keeps back-to-back writes apart.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one pixel after a random gap and wait for it to be taken.
	task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
		input logic [7:0] blue);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {blue, green, red};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Stop sending and wait until every predicted byte has come out.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus and verdict.
	initial begin
		int          sent;
		int          count;
		int          pick;
		logic [7:0]  thr;
		logic [7:0]  level;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] width;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: channel extremes and gray levels on either side of 127.
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd127, 8'd127, 8'd129);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd255, 8'd254);
		send_pixel(8'd1, 8'd1, 8'd1);
		settle();

		// Zero width acts as one pixel per row and cuts the open row short;
		// the threshold write carries bits above its width.
		write_reg(REG_ROW_WIDTH, 13'd0);
		write_reg(REG_GRAY_THRESHOLD, 13'h1F00);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd2);
		settle();

		// Oversized width saturates; top threshold never gives white.
		write_reg(REG_ROW_WIDTH, 13'h1FFF);
		write_reg(REG_GRAY_THRESHOLD, 13'd255);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255);
		settle();

		// Largest legal width, then one just beyond it.
		write_reg(REG_ROW_WIDTH, 13'd4096);
		write_reg(REG_GRAY_THRESHOLD, 13'd254);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd254);
		settle();
		write_reg(REG_ROW_WIDTH, 13'd4097);
		send_pixel(8'd200, 8'd100, 8'd50);
		settle();

		// Random phases, each with its own settings and pacing.
		thr  = 8'd254;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				width = 13'($urandom_range(1, 40));
			end else if (pick == 6) begin
				width = 13'($urandom_range(41, 300));
			end else if (pick == 7) begin
				width = 13'd0;
			end else if (pick == 8) begin
				width = 13'($urandom_range(4096, 8191));
			end else begin
				width = 13'($urandom_range(8, 16));
			end
			write_reg(REG_ROW_WIDTH, width);

			pick = $urandom_range(0, 5);
			if (pick == 0) begin
				thr = 8'd0;
			end else if (pick == 1) begin
				thr = 8'd255;
			end else begin
				thr = 8'($urandom_range(0, 255));
			end
			if (pick == 5) begin
				write_reg(REG_GRAY_THRESHOLD, {5'($urandom_range(1, 31)), thr});
			end else begin
				write_reg(REG_GRAY_THRESHOLD, {5'd0, thr});
			end

			tx_fast = ($urandom_range(0, 3) == 0);
			rx_fast = ($urandom_range(0, 3) == 0);
			count = $urandom_range(4, 48);
			if (count > RANDOM_PIXELS - sent) begin
				count = RANDOM_PIXELS - sent;
			end
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					// Gray right around the threshold.
					level = thr;
					if ($urandom_range(0, 1) == 1 && level != 8'd255) begin
						level = level + 8'd1;
					end
					red   = level;
					green = level;
					blue  = (level <= 8'd253) ? level + 8'($urandom_range(0, 2)) : level;
				end else begin
					red   = 8'($urandom_range(0, 255));
					green = 8'($urandom_range(0, 255));
					blue  = 8'($urandom_range(0, 255));
				end
				send_pixel(red, green, blue);
			end
			sent += count;
			settle();
		end

		if (errors == 0 && outstanding == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
